### design/lvr3_pkg.sv
// ----------------------------------------------------------------------------
// lvr3_pkg
// Shared types and constants of the 3d voxel line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lvr3_pkg;

  // width of a coordinate field on the ports
  localparam int FIELD_BITS = 6;
  // coordinate bits actually used (2 to FIELD_BITS)
  localparam int COORD_BITS = 6;
  // error term width, two's complement
  localparam int ERR_W      = COORD_BITS + 3;
  // bytes-rounded stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int PAINT_W    = 8;
  // command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_WALK = 1'b1
  } back_state_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  // one classified line command
  typedef struct packed {
    coord_t [2:0]                start;
    logic   [2:0]                neg;
    axis_t                       maj;
    axis_t                       mi1;
    axis_t                       mi2;
    coord_t                      len;
    coord_t                      da1;
    coord_t                      da2;
    logic signed [ERR_W-1:0]     ea;
    logic signed [ERR_W-1:0]     eb;
    logic [PAINT_W-1:0]          paint;
  } cmd_t;

  // queue status toward front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

### design/line_voxel_rasterizer_3d_core.sv
// ----------------------------------------------------------------------------
// line_voxel_rasterizer_3d_core
// 3d integer line rasterizer: one command in, one word per voxel out.
// ----------------------------------------------------------------------------
//
//   channel  dir  word                                     last
//   in_      in   start xyz, end xyz, paint                -
//   out_     out  voxel xyz, paint                         final voxel
//
// a line of length L (largest absolute delta) gives L+1 voxel words, up to
// 64, after the walker has loaded the command from the queue.
// the front classifies in the accept cycle; a two-entry command queue
// lets new commands be taken while a line is being walked.
// rst_n is synchronous, active low; it empties the queue and the output.
// out_tready low while a word waits holds the output word and the walker in place.
// ----------------------------------------------------------------------------
`default_nettype none

module line_voxel_rasterizer_3d_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, paint, zero fill
  input  wire logic [lvr3_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // voxel_x, voxel_y, voxel_z, voxel_paint, zero fill
  output logic [lvr3_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tlast
);

  lvr3_pkg::q_status_t q_status;
  lvr3_pkg::cmd_t      push_cmd;
  lvr3_pkg::cmd_t      pop_cmd;
  logic                push;
  logic                pop;

  // classify incoming commands
  lvr3_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // command queue
  lvr3_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  // voxel walker
  lvr3_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

### design/lvr3_front.sv
// ----------------------------------------------------------------------------
// lvr3_front
// Takes line commands, finds deltas, signs, major axis and start error terms.
// ----------------------------------------------------------------------------
`default_nettype none

module lvr3_front (
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lvr3_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire lvr3_pkg::q_status_t               q_status,
  output logic                                   push,
  output lvr3_pkg::cmd_t                         push_cmd
);

  lvr3_pkg::coord_t [2:0] p;
  lvr3_pkg::coord_t [2:0] e;
  lvr3_pkg::coord_t [2:0] a;
  logic [2:0]             neg;
  lvr3_pkg::axis_t        maj;
  lvr3_pkg::axis_t        mi1;
  lvr3_pkg::axis_t        mi2;
  lvr3_pkg::coord_t       len;
  lvr3_pkg::coord_t       da1;
  lvr3_pkg::coord_t       da2;

  // handshake into the queue
  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  // unpack endpoints, keep the low coordinate bits, absolute deltas
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p[k]   = in_tdata[k*lvr3_pkg::FIELD_BITS +: lvr3_pkg::COORD_BITS];
      e[k]   = in_tdata[(k+3)*lvr3_pkg::FIELD_BITS +: lvr3_pkg::COORD_BITS];
      neg[k] = e[k] < p[k];
      a[k]   = neg[k] ? (p[k] - e[k]) : (e[k] - p[k]);
    end
  end

  // major axis, ties to x then y
  always_comb begin
    if (a[0] >= a[1] && a[0] >= a[2]) begin
      maj = lvr3_pkg::AXIS_X;
      mi1 = lvr3_pkg::AXIS_Y;
      mi2 = lvr3_pkg::AXIS_Z;
      len = a[0];
      da1 = a[1];
      da2 = a[2];
    end else if (a[1] >= a[2]) begin
      maj = lvr3_pkg::AXIS_Y;
      mi1 = lvr3_pkg::AXIS_X;
      mi2 = lvr3_pkg::AXIS_Z;
      len = a[1];
      da1 = a[0];
      da2 = a[2];
    end else begin
      maj = lvr3_pkg::AXIS_Z;
      mi1 = lvr3_pkg::AXIS_Y;
      mi2 = lvr3_pkg::AXIS_X;
      len = a[2];
      da1 = a[1];
      da2 = a[0];
    end
  end

  // classified command
  always_comb begin
    push_cmd.start = p;
    push_cmd.neg   = neg;
    push_cmd.maj   = maj;
    push_cmd.mi1   = mi1;
    push_cmd.mi2   = mi2;
    push_cmd.len   = len;
    push_cmd.da1   = da1;
    push_cmd.da2   = da2;
    push_cmd.ea    = signed'({2'b00, da1, 1'b0}) - signed'({3'b000, len});
    push_cmd.eb    = signed'({2'b00, da2, 1'b0}) - signed'({3'b000, len});
    push_cmd.paint = in_tdata[6*lvr3_pkg::FIELD_BITS +: lvr3_pkg::PAINT_W];
  end

endmodule

`default_nettype wire

### design/lvr3_queue.sv
// ----------------------------------------------------------------------------
// lvr3_queue
// Short command queue between the classifying front and the walking back.
// ----------------------------------------------------------------------------
`default_nettype none

module lvr3_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire lvr3_pkg::cmd_t       push_cmd,
  input  wire logic                 pop,
  output lvr3_pkg::cmd_t            pop_cmd,
  output lvr3_pkg::q_status_t       q_status
);

  lvr3_pkg::cmd_t                   mem_r [lvr3_pkg::QUEUE_DEPTH];
  logic [lvr3_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [lvr3_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [lvr3_pkg::QCNT_W-1:0]      cnt_r;

  assign q_status.full  = cnt_r == lvr3_pkg::QCNT_W'(lvr3_pkg::QUEUE_DEPTH);
  assign q_status.empty = cnt_r == '0;
  assign pop_cmd        = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == lvr3_pkg::QPTR_W'(lvr3_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == lvr3_pkg::QPTR_W'(lvr3_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/lvr3_back.sv
// ----------------------------------------------------------------------------
// lvr3_back
// Walks one line a voxel per cycle, while the output slot is free, into a registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module lvr3_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lvr3_pkg::q_status_t               q_status,
  input  wire lvr3_pkg::cmd_t                    pop_cmd,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lvr3_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tlast
);

  lvr3_pkg::back_state_t       state_r;
  lvr3_pkg::back_state_t       state_nxt;
  lvr3_pkg::cmd_t              cmd_r;
  lvr3_pkg::coord_t [2:0]      cur_r;
  lvr3_pkg::coord_t [2:0]      cur_nxt;
  logic signed [lvr3_pkg::ERR_W-1:0] ea_r;
  logic signed [lvr3_pkg::ERR_W-1:0] eb_r;
  logic signed [lvr3_pkg::ERR_W-1:0] ea_nxt;
  logic signed [lvr3_pkg::ERR_W-1:0] eb_nxt;
  logic signed [lvr3_pkg::ERR_W-1:0] twice_len;
  lvr3_pkg::coord_t            left_r;
  logic                        load;
  logic                        emit;
  logic                        slot_free;
  logic                        adv;
  logic                        out_valid_r;
  lvr3_pkg::coord_t [2:0]      out_xyz_r;
  logic [lvr3_pkg::PAINT_W-1:0] out_paint_r;
  logic                        out_last_r;

  assign slot_free = !out_valid_r || out_tready;
  assign pop       = load;

  // walk sequencer
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    emit      = 1'b0;
    case (state_r)
      lvr3_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          load      = 1'b1;
          state_nxt = lvr3_pkg::BK_WALK;
        end
      end
      lvr3_pkg::BK_WALK: begin
        if (slot_free) begin
          emit = 1'b1;
          if (left_r == '0) begin
            state_nxt = lvr3_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lvr3_pkg::BK_IDLE;
      end
    endcase
  end

  // one line step: major axis always, minors on positive error
  always_comb begin
    twice_len = signed'({2'b00, cmd_r.len, 1'b0});
    ea_nxt    = ea_r + signed'({2'b00, cmd_r.da1, 1'b0});
    eb_nxt    = eb_r + signed'({2'b00, cmd_r.da2, 1'b0});
    if (ea_r > 0) begin
      ea_nxt = ea_nxt - twice_len;
    end
    if (eb_r > 0) begin
      eb_nxt = eb_nxt - twice_len;
    end
    for (int k = 0; k < 3; k++) begin
      adv = (cmd_r.maj == lvr3_pkg::axis_t'(2'(k))) ||
            (cmd_r.mi1 == lvr3_pkg::axis_t'(2'(k)) && ea_r > 0) ||
            (cmd_r.mi2 == lvr3_pkg::axis_t'(2'(k)) && eb_r > 0);
      if (!adv) begin
        cur_nxt[k] = cur_r[k];
      end else if (cmd_r.neg[k]) begin
        cur_nxt[k] = cur_r[k] - 1'b1;
      end else begin
        cur_nxt[k] = cur_r[k] + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lvr3_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walker datapath and output word
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r  <= pop_cmd;
      cur_r  <= pop_cmd.start;
      ea_r   <= pop_cmd.ea;
      eb_r   <= pop_cmd.eb;
      left_r <= pop_cmd.len;
    end else if (emit) begin
      cur_r  <= cur_nxt;
      ea_r   <= ea_nxt;
      eb_r   <= eb_nxt;
      left_r <= left_r - 1'b1;
    end
    if (emit) begin
      out_xyz_r   <= cur_r;
      out_paint_r <= cmd_r.paint;
      out_last_r  <= left_r == '0;
    end
  end

  // output word: x, y, z, paint from the lowest bit up
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = lvr3_pkg::OUT_DATA_W'({
                        out_paint_r,
                        lvr3_pkg::FIELD_BITS'(out_xyz_r[2]),
                        lvr3_pkg::FIELD_BITS'(out_xyz_r[1]),
                        lvr3_pkg::FIELD_BITS'(out_xyz_r[0])});

endmodule

`default_nettype wire
